// ===== src/slms_pkg.sv =====
// ----------------------------------------------------------------------------
// slms_pkg
// Shared types and constants of the single-marker LOD scan block.
// ----------------------------------------------------------------------------
`default_nettype none

package slms_pkg;

    // Sizes of the sample stream and the scan.
    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_SITES   = 1048576;
    localparam int CNT_W       = 11;
    localparam int Y_W         = 16;
    localparam int SY_W        = 27;
    localparam int SYY_W       = 41;
    localparam int SITE_W      = 20;
    localparam int LOD_W       = 20;
    localparam int H2_W        = 16;

    // Widths of the end-of-site arithmetic.
    localparam int A_W    = 52;
    localparam int K_W    = 19;
    localparam int E_W    = 38;
    localparam int XW     = 74;
    localparam int PW     = 80;
    localparam int BW     = 38;
    localparam int P_W    = 7;
    localparam int FRAC_W = 24;
    localparam int L_W    = P_W + FRAC_W;
    localparam int T_W    = 31;
    localparam int IT_W   = 5;

    localparam int IN_W  = 24;
    localparam int OUT_W = SITE_W + LOD_W + LOD_W + SITE_W + H2_W;

    localparam logic [CNT_W-1:0]  SAMPLE_CAP = CNT_W'(MAX_SAMPLES);
    localparam logic [SITE_W-1:0] SITE_LAST  = SITE_W'(MAX_SITES - 1);
    localparam logic [IT_W-1:0]   LOG_STEPS  = IT_W'(FRAC_W);
    localparam logic [IT_W-1:0]   DIV_STEPS  = IT_W'(H2_W);
    localparam logic [P_W-1:0]    P_TOP      = P_W'(XW - 1);
    localparam logic [BW-1:0]     LOG10_2    = BW'(64'd1292913987);
    localparam logic [LOD_W-1:0]  LOD_MAX    = '1;
    localparam logic [H2_W-1:0]   H2_MAX     = '1;

    // Operations of the shared serial multiplier.
    typedef enum logic [3:0] {
        MUL_NSYY,
        MUL_SYSQ,
        MUL_K,
        MUL_NSY1,
        MUL_MSY,
        MUL_N0,
        MUL_E2,
        MUL_DC,
        MUL_NT
    } mul_op_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_ACC,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_CHK_N0,
        ST_CHK_N1,
        ST_NORM,
        ST_LOG,
        ST_DIFF,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    acc;
        logic    mul_start;
        mul_op_t mul_op;
        logic    n1_calc;
        logic    zero;
        logic    sat;
        logic    norm_load;
        logic    norm_sel;
        logic    norm_step;
        logic    log_load;
        logic    log_step;
        logic    log_store;
        logic    store_sel;
        logic    diff;
        logic    div_load;
        logic    div_step;
        logic    finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic n0_zero;
        logic n1_zero;
        logic norm_done;
        logic log_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== src/single_marker_lod_scan_top.sv =====
// Samples are taken one per cycle while a site accumulates.
// After the last sample of a site the block stops taking samples while a
// one-bit-per-cycle shift-add multiplier, two 24-step log2 loops with
// one-bit normalisation and a 16-step divider fit it; a site with nothing
// to fit skips the loops and the divider. The result then sits in an output
// register; the next site may accumulate. Asynchronous active-low reset
// clears all sums, the site counter, the best tracking and m_tvalid.
// ----------------------------------------------------------------------------
// single_marker_lod_scan_top
// Single-marker regression LOD scan over a stream of per-sample transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module single_marker_lod_scan_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // phenotype [15:0], allele [16], zero [23:17]
    input  wire logic [slms_pkg::IN_W-1:0]   s_tdata,
    input  wire logic                        s_tlast,
    // first_site
    input  wire logic                        s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // site_number [19:0], lod [39:20], best_lod [59:40], best_site [79:60],
    // best_h2 [95:80]
    output logic [slms_pkg::OUT_W-1:0]       m_tdata
);
    import slms_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Sequencing.
    slms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    slms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_phen   (s_tdata[Y_W-1:0]),
        .in_allele (s_tdata[Y_W]),
        .in_first  (s_tuser),
        .out_ready (m_tready),
        .st        (st),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== src/slms_ctrl.sv =====
// ----------------------------------------------------------------------------
// slms_ctrl
// Controller that sequences accumulation and the end-of-site computation.
// ----------------------------------------------------------------------------
`default_nettype none

module slms_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    input  wire slms_pkg::status_t st,
    output logic                  in_ready,
    output slms_pkg::cmd_t        cmd
);
    import slms_pkg::*;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    logic    sel_reg, sel_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            op_reg    <= MUL_NSYY;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sel_next    = sel_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_op  = op_reg;
        case (state_reg)
            ST_ACC:
            begin
                in_ready = 1'b1;
                cmd.acc  = in_valid;
                if (in_valid && in_last)
                begin
                    op_next    = MUL_NSYY;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (st.mul_done)
                begin
                    state_next = ST_MUL_GO;
                    case (op_reg)
                        MUL_NSYY: op_next = MUL_SYSQ;
                        MUL_SYSQ: op_next = MUL_K;
                        MUL_K:    op_next = MUL_NSY1;
                        MUL_NSY1: op_next = MUL_MSY;
                        MUL_MSY:  op_next = MUL_N0;
                        MUL_N0:   op_next = MUL_E2;
                        MUL_E2:   state_next = ST_CHK_N0;
                        MUL_DC:   op_next = MUL_NT;
                        MUL_NT:   state_next = ST_DIV_LOAD;
                        default:  state_next = ST_CHK_N0;
                    endcase
                end
            end
            ST_CHK_N0:
            begin
                cmd.n1_calc = 1'b1;
                if (st.n0_zero)
                begin
                    cmd.zero   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CHK_N1;
                end
            end
            ST_CHK_N1:
            begin
                if (st.n1_zero)
                begin
                    cmd.sat    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.norm_load = 1'b1;
                    cmd.norm_sel  = 1'b0;
                    sel_next      = 1'b0;
                    state_next    = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (st.norm_done)
                begin
                    cmd.log_load = 1'b1;
                    state_next   = ST_LOG;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_LOG:
            begin
                if (st.log_done)
                begin
                    cmd.log_store = 1'b1;
                    cmd.store_sel = sel_reg;
                    if (!sel_reg)
                    begin
                        cmd.norm_load = 1'b1;
                        cmd.norm_sel  = 1'b1;
                        sel_next      = 1'b1;
                        state_next    = ST_NORM;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
                else
                begin
                    cmd.log_step = 1'b1;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                op_next    = MUL_DC;
                state_next = ST_MUL_GO;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/slms_dp.sv =====
// ----------------------------------------------------------------------------
// slms_dp
// Datapath: per-site sums, serial multiplier, log2 unit, divider, best
// tracking and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slms_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire slms_pkg::cmd_t             cmd,
    input  wire logic [slms_pkg::Y_W-1:0]   in_phen,
    input  wire logic                       in_allele,
    input  wire logic                       in_first,
    input  wire logic                       out_ready,
    output slms_pkg::status_t               st,
    output logic                            out_valid,
    output logic [slms_pkg::OUT_W-1:0]      out_data
);
    import slms_pkg::*;

    // Per-site sums.
    logic [CNT_W-1:0]        cnt_reg, m_cnt_reg;
    logic signed [SY_W-1:0]  sy_reg, sy1_reg;
    logic [SYY_W-1:0]        syy_reg;
    // Scan tracking.
    logic [SITE_W-1:0]       site_reg, best_site_reg;
    logic [LOD_W-1:0]        best_lod_reg;
    logic [H2_W-1:0]         best_h2_reg;
    logic                    best_valid_reg;
    // Intermediate results.
    logic [A_W-1:0]          t1_reg, aval_reg;
    logic [K_W-1:0]          k_reg;
    logic signed [E_W-1:0]   e_reg;
    logic [XW-1:0]           n0_reg, e2_reg, n1_reg;
    logic [L_W-1:0]          l0_reg, l1_reg, d_reg;
    logic [T_W-1:0]          t_reg;
    logic [LOD_W-1:0]        lod_reg;
    logic [H2_W-1:0]         h2_reg;
    // Serial multiplier.
    logic [PW-1:0]           a_reg, prod_reg;
    logic [BW-1:0]           b_reg;
    logic                    neg_reg, busy_reg;
    mul_op_t                 op_reg;
    // Log2 and divider.
    logic [XW-1:0]           x_reg;
    logic [P_W-1:0]          p_reg;
    logic [31:0]             mant_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic [IT_W-1:0]         iter_reg;
    logic [XW:0]             r_reg;
    // Output.
    logic                    ovalid_reg;
    logic [OUT_W-1:0]        odata_reg;

    logic signed [Y_W-1:0]     y;
    logic signed [2*Y_W-1:0]   ysq;
    logic [SY_W-1:0]           sy_abs, sy1_abs;
    logic [E_W-1:0]            e_abs;
    logic [CNT_W-1:0]          n_minus_m;
    logic [PW-1:0]             a_in;
    logic [BW-1:0]             b_in;
    logic                      neg_in;
    logic                      mul_done;
    logic signed [E_W-1:0]     prod_s;
    logic [63:0]               sq;
    logic [32:0]               sq_sh;
    logic [XW:0]               r_sh;
    logic [43:0]               lod_sum;
    logic [26:0]               lod_raw;
    logic                      upd;
    logic [LOD_W-1:0]          bl_n;
    logic [SITE_W-1:0]         bs_n;
    logic [H2_W-1:0]           bh_n;

    assign y       = $signed(in_phen);
    assign ysq     = y * y;
    assign sy_abs  = sy_reg[SY_W-1] ? SY_W'(-sy_reg) : SY_W'(sy_reg);
    assign sy1_abs = sy1_reg[SY_W-1] ? SY_W'(-sy1_reg) : SY_W'(sy1_reg);
    assign e_abs   = e_reg[E_W-1] ? E_W'(-e_reg) : E_W'(e_reg);
    assign n_minus_m = cnt_reg - m_cnt_reg;

    // Accumulation of the sums and scan tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            m_cnt_reg      <= '0;
            sy_reg         <= '0;
            sy1_reg        <= '0;
            syy_reg        <= '0;
            site_reg       <= '0;
            best_site_reg  <= '0;
            best_lod_reg   <= '0;
            best_h2_reg    <= '0;
            best_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            cnt_reg        <= '0;
            m_cnt_reg      <= '0;
            sy_reg         <= '0;
            sy1_reg        <= '0;
            syy_reg        <= '0;
            site_reg       <= (site_reg == SITE_LAST) ? '0 : site_reg + 1'b1;
            best_site_reg  <= bs_n;
            best_lod_reg   <= bl_n;
            best_h2_reg    <= bh_n;
            best_valid_reg <= 1'b1;
        end
        else if (cmd.acc)
        begin
            if (in_first)
            begin
                site_reg       <= '0;
                best_site_reg  <= '0;
                best_lod_reg   <= '0;
                best_h2_reg    <= '0;
                best_valid_reg <= 1'b0;
            end
            if (cnt_reg < SAMPLE_CAP)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sy_reg  <= sy_reg + SY_W'(y);
                syy_reg <= syy_reg + SYY_W'(unsigned'(ysq));
                if (in_allele)
                begin
                    m_cnt_reg <= m_cnt_reg + 1'b1;
                    sy1_reg   <= sy1_reg + SY_W'(y);
                end
            end
        end
    end

    // Operand selection for the serial multiplier.
    always_comb
    begin
        a_in   = '0;
        b_in   = '0;
        neg_in = 1'b0;
        case (cmd.mul_op)
            MUL_NSYY: begin a_in = PW'(syy_reg);  b_in = BW'(cnt_reg); end
            MUL_SYSQ: begin a_in = PW'(sy_abs);   b_in = BW'(sy_abs); end
            MUL_K:    begin a_in = PW'(m_cnt_reg); b_in = BW'(n_minus_m); end
            MUL_NSY1:
            begin
                a_in   = PW'(sy1_abs);
                b_in   = BW'(cnt_reg);
                neg_in = sy1_reg[SY_W-1];
            end
            MUL_MSY:
            begin
                a_in   = PW'(sy_abs);
                b_in   = BW'(m_cnt_reg);
                neg_in = sy_reg[SY_W-1];
            end
            MUL_N0:   begin a_in = PW'(aval_reg); b_in = BW'(k_reg); end
            MUL_E2:   begin a_in = PW'(e_abs);    b_in = BW'(e_abs); end
            MUL_DC:   begin a_in = PW'(d_reg);    b_in = LOG10_2; end
            MUL_NT:   begin a_in = PW'(t_reg);    b_in = BW'(cnt_reg); end
            default:  begin a_in = '0;            b_in = '0; end
        endcase
    end

    assign mul_done = busy_reg && (b_reg == '0);
    assign prod_s   = neg_reg ? -$signed(prod_reg[E_W-1:0]) : $signed(prod_reg[E_W-1:0]);
    assign lod_sum  = {1'b0, prod_reg[42:0]} + 44'd65536;
    assign lod_raw  = lod_sum[43:17];

    // Shift-add multiplier, one multiplier bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (cmd.mul_start)
        begin
            busy_reg <= 1'b1;
        end
        else if (mul_done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            a_reg    <= a_in;
            b_reg    <= b_in;
            neg_reg  <= neg_in;
            op_reg   <= cmd.mul_op;
            prod_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                prod_reg <= prod_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    // Write the finished product to its destination.
    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            case (op_reg)
                MUL_NSYY: t1_reg   <= prod_reg[A_W-1:0];
                MUL_SYSQ: aval_reg <= t1_reg - prod_reg[A_W-1:0];
                MUL_K:    k_reg    <= prod_reg[K_W-1:0];
                MUL_NSY1: e_reg    <= prod_s;
                MUL_MSY:  e_reg    <= e_reg - prod_s;
                MUL_N0:   n0_reg   <= prod_reg[XW-1:0];
                MUL_E2:   e2_reg   <= prod_reg[XW-1:0];
                MUL_DC:   t_reg    <= prod_reg[62:32];
                MUL_NT:   lod_reg  <= (lod_raw > 27'(LOD_MAX)) ? LOD_MAX : lod_raw[LOD_W-1:0];
                default:  t_reg    <= t_reg;
            endcase
        end
        else if (cmd.zero)
        begin
            lod_reg <= '0;
        end
        else if (cmd.sat)
        begin
            lod_reg <= LOD_MAX;
        end
    end

    // Residual numerator and log difference.
    always_ff @(posedge clk)
    begin
        if (cmd.n1_calc)
        begin
            n1_reg <= (e2_reg >= n0_reg) ? '0 : n0_reg - e2_reg;
        end
        if (cmd.diff)
        begin
            d_reg <= (l0_reg > l1_reg) ? l0_reg - l1_reg : '0;
        end
    end

    // Log2: normalise one bit a cycle, then square the mantissa per fraction bit.
    assign sq    = mant_reg * mant_reg;
    assign sq_sh = sq[63:31];

    always_ff @(posedge clk)
    begin
        if (cmd.norm_load)
        begin
            x_reg <= cmd.norm_sel ? n1_reg : n0_reg;
            p_reg <= P_TOP;
        end
        else if (cmd.norm_step)
        begin
            x_reg <= x_reg << 1;
            p_reg <= p_reg - 1'b1;
        end
        if (cmd.log_load)
        begin
            mant_reg <= x_reg[XW-1:XW-32];
            frac_reg <= '0;
        end
        else if (cmd.log_step)
        begin
            frac_reg <= {frac_reg[FRAC_W-2:0], sq_sh[32]};
            mant_reg <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        end
        if (cmd.log_store)
        begin
            if (cmd.store_sel)
            begin
                l1_reg <= {p_reg, frac_reg};
            end
            else
            begin
                l0_reg <= {p_reg, frac_reg};
            end
        end
    end

    // Step counter shared by the log loop and the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (cmd.log_load || cmd.div_load)
        begin
            iter_reg <= '0;
        end
        else if (cmd.log_step || cmd.div_step)
        begin
            iter_reg <= iter_reg + 1'b1;
        end
    end

    // Restoring division for h2, one quotient bit a cycle.
    assign r_sh = r_reg << 1;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            r_reg  <= {1'b0, e2_reg};
            h2_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (r_sh >= {1'b0, n0_reg})
            begin
                r_reg  <= r_sh - {1'b0, n0_reg};
                h2_reg <= {h2_reg[H2_W-2:0], 1'b1};
            end
            else
            begin
                r_reg  <= r_sh;
                h2_reg <= {h2_reg[H2_W-2:0], 1'b0};
            end
        end
        else if (cmd.zero)
        begin
            h2_reg <= '0;
        end
        else if (cmd.sat)
        begin
            h2_reg <= H2_MAX;
        end
    end

    // Best-site update.
    assign upd  = !best_valid_reg || (lod_reg > best_lod_reg);
    assign bl_n = upd ? lod_reg : best_lod_reg;
    assign bs_n = upd ? site_reg : best_site_reg;
    assign bh_n = upd ? h2_reg : best_h2_reg;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            odata_reg <= {bh_n, bs_n, bl_n, lod_reg, site_reg};
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_data     = odata_reg;
    assign st.mul_done  = mul_done;
    assign st.n0_zero   = (n0_reg == '0);
    assign st.n1_zero   = (n1_reg == '0);
    assign st.norm_done = x_reg[XW-1];
    assign st.log_done  = (iter_reg == LOG_STEPS);
    assign st.div_done  = (iter_reg == DIV_STEPS);
    assign st.out_free  = !ovalid_reg || out_ready;

endmodule

`default_nettype wire

// ===== tb/sv/single_marker_lod_scan_top_tb.sv =====
// ----------------------------------------------------------------------------
// single_marker_lod_scan_top_tb
// Self-checking testbench for the single-marker LOD scan block. Sites are
// streamed as runs of sample transactions. A bit-accurate predictor works
// out each site's LOD, best LOD, best site and h2 at acceptance time, and
// every result transaction is checked field by field against the oldest
// prediction. Both sides idle at random, and the receiver holds off once for
// a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module single_marker_lod_scan_top_tb;

    import slms_pkg::*;

    localparam int        CYCLE_LIMIT = 4000000;
    localparam longint    LOG10_2_Q32 = 64'd1292913987;

    // Stimulus modes for one site.
    typedef enum int {
        SITE_NOISE,
        SITE_EFFECT,
        SITE_FLAT_ALLELE,
        SITE_FLAT_PHENO,
        SITE_EXACT
    } site_kind_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               s_tlast;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    // Predictor state.
    int                 acc_n;
    int                 acc_m;
    longint             acc_sy;
    longint unsigned    acc_syy;
    longint             acc_sy1;
    logic [SITE_W-1:0]  site_ctr;
    logic [LOD_W-1:0]   top_lod;
    logic [SITE_W-1:0]  top_site;
    logic [H2_W-1:0]    top_h2;
    bit                 top_valid;

    logic [OUT_W-1:0]   pending_results[$];
    int                 fail_count;
    int                 cycle_count;
    int                 recv_hold;

    single_marker_lod_scan_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Fixed-point log2 in Q7.24, truncating squaring method.
    function automatic longint unsigned log2_q24(logic [127:0] x);
        int              p;
        logic [63:0]     mant;
        logic [23:0]     frac;
        p = 0;
        frac = '0;
        for (int i = 0; i < 128; i++)
            if (x[i])
                p = i;
        if (p >= 31)
            mant = 64'((x >> (p - 31)) & 128'hFFFF_FFFF);
        else
            mant = 64'(x) << (31 - p);
        for (int i = 0; i < 24; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = {frac[22:0], 1'b0};
            if (mant >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        return (longint'(p) << 24) | longint'(frac);
    endfunction

    // Predict the effect of one accepted sample; returns 1 with a result.
    function automatic bit predict_site(logic signed [15:0] y, bit al, bit last,
                                        bit first, output logic [OUT_W-1:0] res);
        longint unsigned  a_val;
        longint unsigned  k_val;
        longint           e_val;
        longint unsigned  e_abs;
        longint unsigned  sy_abs;
        logic [127:0]     n0;
        logic [127:0]     e2;
        logic [127:0]     rem;
        longint unsigned  l0;
        longint unsigned  l1;
        longint unsigned  d;
        longint unsigned  t;
        longint unsigned  lod_w;
        logic [LOD_W-1:0] lod;
        logic [H2_W-1:0]  h2;
        res = '0;
        lod = '0;
        h2 = '0;
        if (first)
        begin
            top_valid = 0;
            top_lod = '0;
            top_site = '0;
            top_h2 = '0;
            site_ctr = '0;
        end
        if (acc_n < MAX_SAMPLES)
        begin
            acc_n++;
            acc_sy += longint'(y);
            acc_syy += longint'(y) * longint'(y);
            if (al)
            begin
                acc_m++;
                acc_sy1 += longint'(y);
            end
        end
        if (!last)
            return 0;

        sy_abs = acc_sy < 0 ? -acc_sy : acc_sy;
        a_val = longint'(acc_n) * acc_syy - sy_abs * sy_abs;
        k_val = longint'(acc_m) * longint'(acc_n - acc_m);
        e_val = longint'(acc_n) * acc_sy1 - longint'(acc_m) * acc_sy;
        e_abs = e_val < 0 ? -e_val : e_val;
        n0 = 128'(a_val) * 128'(k_val);
        e2 = 128'(e_abs) * 128'(e_abs);

        if (n0 != 0)
        begin
            if (e2 >= n0)
            begin
                // A perfect fit leaves no residual.
                lod = LOD_MAX;
                h2 = H2_MAX;
            end
            else
            begin
                l0 = log2_q24(n0);
                l1 = log2_q24(n0 - e2);
                d = l0 > l1 ? l0 - l1 : 0;
                t = (d * LOG10_2_Q32) >> 32;
                lod_w = (longint'(acc_n) * t + 64'h1_0000) >> 17;
                lod = lod_w > 64'hF_FFFF ? LOD_MAX : LOD_W'(lod_w);
                rem = e2;
                for (int i = 0; i < 16; i++)
                begin
                    rem = rem << 1;
                    h2 = {h2[14:0], 1'b0};
                    if (rem >= n0)
                    begin
                        rem = rem - n0;
                        h2[0] = 1'b1;
                    end
                end
            end
        end

        if (!top_valid || lod > top_lod)
        begin
            top_valid = 1;
            top_lod = lod;
            top_site = site_ctr;
            top_h2 = h2;
        end
        res = {top_h2, top_site, top_lod, lod, site_ctr};
        site_ctr = site_ctr + 1'b1;
        acc_n = 0;
        acc_m = 0;
        acc_sy = 0;
        acc_syy = 0;
        acc_sy1 = 0;
        return 1;
    endfunction

    // Offer one sample transaction after a random gap and wait for acceptance.
    task automatic send_sample(logic signed [15:0] y, bit al, bit last, bit first);
        int                gap;
        logic [OUT_W-1:0]  res;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, al, y};
        s_tlast  <= last;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_site(y, al, last, first, res))
            pending_results = {pending_results, res};
    endtask

    // Send one whole site of the given kind and size.
    task automatic send_site(site_kind_t kind, int n, bit first);
        logic signed [15:0] base;
        logic signed [15:0] effect;
        logic signed [15:0] y;
        bit                 al;
        bit                 flat_al;
        base = 16'($urandom);
        effect = 16'($urandom_range(0, 8000)) - 16'sd4000;
        flat_al = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            al = (n >= 2 && i < 2) ? bit'(i) : bit'($urandom_range(0, 1));
            case (kind)
                SITE_NOISE:       y = 16'($urandom);
                SITE_EFFECT:      y = (al ? effect : -effect)
                                      + 16'($urandom_range(0, 2000)) - 16'sd1000;
                SITE_FLAT_ALLELE:
                begin
                    al = flat_al;
                    y = 16'($urandom);
                end
                SITE_FLAT_PHENO:  y = base;
                default:          y = al ? base : effect;
            endcase
            send_sample(y, al, i == n - 1, first && i == 0);
        end
    endtask

    // Pause the sender until every predicted result has arrived.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    task automatic test_extremes;
        send_sample(16'sh8000, 1'b0, 1'b0, 1'b1);
        send_sample(16'sh7FFF, 1'b1, 1'b0, 1'b0);
        send_sample(16'sh8000, 1'b1, 1'b0, 1'b0);
        send_sample(16'sh7FFF, 1'b0, 1'b1, 1'b0);
        // A single sample, then a site that is a perfect fit.
        send_sample(16'sh1234, 1'b1, 1'b1, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0, 1'b0);
        send_sample(16'sh7FFF, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_degenerate_sites;
        send_site(SITE_FLAT_ALLELE, 5, 1'b0);
        send_site(SITE_FLAT_PHENO, 4, 1'b0);
        send_site(SITE_EXACT, 6, 1'b0);
    endtask

    // Identical sites give equal LODs; the earlier site must stay best.
    task automatic test_ties;
        for (int r = 0; r < 2; r++)
        begin
            send_sample(16'sh0100, 1'b0, 1'b0, r == 0);
            send_sample(16'sh0300, 1'b1, 1'b0, 1'b0);
            send_sample(16'sh0180, 1'b0, 1'b0, 1'b0);
            send_sample(16'sh0250, 1'b1, 1'b1, 1'b0);
        end
    endtask

    task automatic test_oversize_site;
        send_site(SITE_EFFECT, MAX_SAMPLES + 6, 1'b0);
        drain();
    endtask

    // The receiver holds off while several sites are offered.
    task automatic test_backpressure;
        recv_hold = 3000;
        for (int s = 0; s < 6; s++)
            send_site(SITE_EFFECT, 4, 1'b0);
        drain();
    endtask

    task automatic test_random(int items);
        int         sent;
        int         n;
        int         pick;
        site_kind_t kind;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            n = pick < 3 ? $urandom_range(1, 2) : $urandom_range(3, 14);
            if ($urandom_range(0, 49) == 0)
                n = $urandom_range(60, 200);
            pick = $urandom_range(0, 99);
            kind = pick < 40 ? SITE_EFFECT : pick < 80 ? SITE_NOISE :
                   pick < 87 ? SITE_EXACT : pick < 94 ? SITE_FLAT_ALLELE
                   : SITE_FLAT_PHENO;
            send_site(kind, n, $urandom_range(0, 19) == 0);
            sent += n;
        end
    endtask

    // Receiver: random stalls, with one long hold-off on request.
    initial
    begin
        int w;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 3);
            if (recv_hold > 0)
            begin
                w = recv_hold;
                recv_hold = 0;
            end
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v,
                                        logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("Unexpected result transaction: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("site_number", exp_r[19:0],  m_tdata[19:0]);
                check_field("lod",         exp_r[39:20], m_tdata[39:20]);
                check_field("best_lod",    exp_r[59:40], m_tdata[59:40]);
                check_field("best_site",   exp_r[79:60], m_tdata[79:60]);
                check_field("best_h2",     exp_r[95:80], m_tdata[95:80]);
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** single_marker_lod_scan_top: FAILED **");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        fail_count = 0;
        cycle_count = 0;
        recv_hold = 0;
        acc_n = 0;
        acc_m = 0;
        acc_sy = 0;
        acc_syy = 0;
        acc_sy1 = 0;
        site_ctr = '0;
        top_lod = '0;
        top_site = '0;
        top_h2 = '0;
        top_valid = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        s_tuser <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_degenerate_sites();
        test_ties();
        drain();
        test_oversize_site();
        test_backpressure();
        test_random(720);
        drain();

        if (fail_count == 0)
            $display("** single_marker_lod_scan_top: PASSED **");
        else
            $display("** single_marker_lod_scan_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/slms_pkg.sv
src/slms_ctrl.sv
src/slms_dp.sv
src/single_marker_lod_scan_top.sv
tb/sv/single_marker_lod_scan_top_tb.sv
